// ----- rtl/float_stream_sum_reduce_unit_defines.svh -----
// Assertion macros for the float stream sum-reduce block.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef FLOAT_STREAM_SUM_REDUCE_UNIT_DEFINES_SVH
`define FLOAT_STREAM_SUM_REDUCE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FSSR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FSSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FSSR_ASSERT_IMP(lbl, ante, cons)
`define FSSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/fssr_pkg.sv -----
// Shared constants for the float stream sum-reduce block.
// No dependencies.
package fssr_pkg;
  localparam logic [1:0] FMT_FP32 = 2'd0;
  localparam logic [1:0] FMT_FP16 = 2'd1;
  localparam logic [1:0] FMT_BF16 = 2'd2;
  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
endpackage

// ----- rtl/fssr_if.sv -----
// Valid/ready channel interfaces for the sum-reduce block.
// Depends on nothing; payload widths are fixed by the data formats.
interface fssr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_bits;
  logic        last_element;
  modport source (output valid, element_bits, last_element, input ready);
  modport sink (input valid, element_bits, last_element, output ready);
endinterface

interface fssr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;
  modport source (output valid, sum_bits, input ready);
  modport sink (input valid, sum_bits, output ready);
endinterface

interface fssr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] element_format;
  modport source (output valid, element_format, input ready);
  modport sink (input valid, element_format, output ready);
endinterface

// ----- rtl/fssr_widen.sv -----
// Widens one element (binary32, binary16 or bfloat16) to binary32 exactly.
// Depends on fssr_pkg.
module fssr_widen (
  input  logic [31:0] raw,
  input  logic [1:0]  fmt,
  output logic [31:0] wide
);
  logic [4:0]  he;
  logic [9:0]  hf;
  logic [3:0]  p;
  logic [9:0]  nf;
  logic [7:0]  e32;
  logic [31:0] h32;

  always_comb begin
    he = raw[14:10];
    hf = raw[9:0];
    p  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hf[i]) p = 4'(i);
    end
    nf  = hf << (4'd10 - p);
    e32 = 8'd103 + {4'd0, p};
    if (he == 5'd31) begin
      h32 = {raw[15], 8'hFF, hf, 13'd0};
    end else if (he == 5'd0) begin
      if (hf == 10'd0) h32 = {raw[15], 31'd0};
      else h32 = {raw[15], e32, nf, 13'd0};
    end else begin
      h32 = {raw[15], 8'({3'd0, he} + 8'd112), hf, 13'd0};
    end
    case (fmt)
      fssr_pkg::FMT_FP16: wide = h32;
      fssr_pkg::FMT_BF16: wide = {raw[15:0], 16'd0};
      default:            wide = raw;
    endcase
  end
endmodule

// ----- rtl/fssr_add.sv -----
// Binary32 adder, round to nearest even, full subnormal support.
// Depends on fssr_pkg.
module fssr_add (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] sum
);
  logic [7:0]  ea, eb, d;
  logic [31:0] big, sml;
  logic [7:0]  eg, es;
  logic [26:0] mg, ms, msh;
  logic        sticky;
  logic [27:0] m;
  logic [8:0]  e9;
  logic [4:0]  p, lz, sh;
  logic [2:0]  rb;
  logic [24:0] mr;
  logic        a_nan, b_nan, a_inf, b_inf, a_z, b_z;

  always_comb begin
    ea    = a[30:23];
    eb    = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF);
    b_inf = (eb == 8'hFF);
    a_z   = (a[30:0] == 31'd0);
    b_z   = (b[30:0] == 31'd0);
    if (a[30:0] < b[30:0]) begin
      big = b; sml = a;
    end else begin
      big = a; sml = b;
    end
    eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mg = {(big[30:23] != 8'd0), big[22:0], 3'd0};
    ms = {(sml[30:23] != 8'd0), sml[22:0], 3'd0};
    d  = eg - es;
    sticky = |(ms & ((27'd1 << d) - 27'd1));
    if (d >= 8'd27) msh = {26'd0, |ms};
    else msh = (ms >> d) | {26'd0, sticky};
    e9 = {1'b0, eg};
    p  = 5'd0;
    lz = 5'd0;
    sh = 5'd0;
    if (big[31] == sml[31]) begin
      m = {1'b0, mg} + {1'b0, msh};
      if (m[27]) begin
        m  = (m >> 1) | {27'd0, m[0]};
        e9 = e9 + 9'd1;
      end
    end else begin
      m = {1'b0, mg} - {1'b0, msh};
      for (int i = 0; i < 27; i++) begin
        if (m[i]) p = 5'(i);
      end
      lz = 5'd26 - p;
      sh = ({3'd0, lz} < (eg - 8'd1)) ? lz : 5'(eg - 8'd1);
      m  = m << sh;
      e9 = e9 - {4'd0, sh};
    end
    rb = m[2:0];
    mr = m[27:3];
    if (rb > 3'd4 || (rb == 3'd4 && mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      e9 = e9 + 9'd1;
    end
    if (a_nan) sum = a | 32'h0040_0000;
    else if (b_nan) sum = b | 32'h0040_0000;
    else if (a_inf || b_inf) begin
      if (a_inf && b_inf && (a[31] != b[31])) sum = fssr_pkg::QNAN32;
      else sum = a_inf ? a : b;
    end
    else if (a_z && b_z) sum = {a[31] & b[31], 31'd0};
    else if (a_z) sum = b;
    else if (b_z) sum = a;
    else if (big[31] != sml[31] && m == 28'd0) sum = 32'd0;
    else if (e9 >= 9'd255) sum = {big[31], 8'hFF, 23'd0};
    else sum = {big[31], (mr[23] ? e9[7:0] : 8'd0), mr[22:0]};
  end
endmodule

// ----- rtl/fssr_narrow.sv -----
// Narrows a binary32 sum to the element format, round to nearest even.
// Depends on fssr_pkg.
module fssr_narrow (
  input  logic [31:0] u,
  input  logic [1:0]  fmt,
  output logic [31:0] r
);
  logic [7:0]  e;
  logic [23:0] m;
  logic [8:0]  e16;
  logic [14:0] q;
  logic [12:0] rem13;
  logic [4:0]  sh;
  logic [23:0] mask, rem, half;
  logic [15:0] h, bf;
  logic [31:0] t;

  always_comb begin
    e     = u[30:23];
    m     = {1'b1, u[22:0]};
    e16   = {1'b0, e} - 9'd112;
    rem13 = m[12:0];
    sh    = 5'd0;
    mask  = 24'd0;
    rem   = 24'd0;
    half  = 24'd0;
    q     = 15'd0;
    if (e == 8'hFF) begin
      h = (u[22:0] != 23'd0) ? {u[31], 15'h7E00 | {5'd0, u[22:13]}} : {u[31], 15'h7C00};
    end else if (e == 8'd0) begin
      h = {u[31], 15'd0};
    end else if (!e16[8] && e16 >= 9'd31) begin
      h = {u[31], 15'h7C00};
    end else if (!e16[8] && e16 != 9'd0) begin
      q = {e16[4:0], 10'd0} + {5'd0, m[22:13]};
      if (rem13 > 13'h1000 || (rem13 == 13'h1000 && q[0])) q = q + 15'd1;
      h = {u[31], q};
    end else if (e < 8'd102) begin
      h = {u[31], 15'd0};
    end else begin
      sh   = 5'(8'd126 - e);
      q    = 15'(m >> sh);
      mask = (24'd1 << sh) - 24'd1;
      rem  = m & mask;
      half = 24'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && q[0])) q = q + 15'd1;
      h = {u[31], q};
    end
    t  = u + 32'h7FFF + {31'd0, u[16]};
    bf = ((e == 8'hFF) && (u[22:0] != 23'd0)) ? (u[31:16] | 16'h0040) : t[31:16];
    case (fmt)
      fssr_pkg::FMT_FP16: r = {16'd0, h};
      fssr_pkg::FMT_BF16: r = {16'd0, bf};
      default:            r = u;
    endcase
  end
endmodule

// ----- rtl/float_stream_sum_reduce_unit.sv -----
// Float stream sum-reduce: one element per cycle unless a last element stalls.
// Path: input register, then finished-sum slot, then output register.
// Throughput: 1 element/cycle; set by the combinational binary32 add feeding
// the accumulator register. A last element stalls only while the sum slot
// and output register are both held by the sink.
// Reset (rst_n low, synchronous): accumulator +0, format binary32, no result.
`include "float_stream_sum_reduce_unit_defines.svh"
module float_stream_sum_reduce_unit (
  input  logic              clk,
  input  logic              rst_n,
  fssr_in_if.sink           in_ch,
  fssr_out_if.source        out_ch,
  fssr_cfg_if.sink          cfg_ch
);
  // configuration register, captured per element at its transaction
  logic [1:0]  fmt_r;

  // stage 1: input register
  logic        s1_v_r, s1_last_r;
  logic [31:0] s1_bits_r;
  logic [1:0]  s1_fmt_r;

  // running binary32 total
  logic [31:0] acc_r;

  // finished sum waiting for narrowing
  logic        fin_v_r;
  logic [31:0] fin_sum_r;
  logic [1:0]  fin_fmt_r;

  // output register
  logic        out_v_r;
  logic [31:0] out_bits_r;

  logic [31:0] wide, sum, narrowed;
  logic        fin_move, fin_free, adv, in_acc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= fssr_pkg::FMT_FP32;
    else if (cfg_ch.valid) fmt_r <= cfg_ch.element_format;
  end

  // Handshake chain: out reg frees fin, fin frees stage 1 for a last element.
  assign fin_move = fin_v_r && (!out_v_r || out_ch.ready);
  assign fin_free = !fin_v_r || fin_move;
  assign adv      = s1_v_r && (!s1_last_r || fin_free);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc   = in_ch.valid && in_ch.ready;

  fssr_widen u_widen (.raw(s1_bits_r), .fmt(s1_fmt_r), .wide(wide));
  fssr_add   u_add   (.a(acc_r), .b(wide), .sum(sum));
  fssr_narrow u_narrow (.u(fin_sum_r), .fmt(fin_fmt_r), .r(narrowed));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bits_r <= in_ch.element_bits;
      s1_last_r <= in_ch.last_element;
      s1_fmt_r  <= fmt_r;
    end
  end

  // accumulator clears after a last element
  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= 32'd0;
    else if (adv) acc_r <= s1_last_r ? 32'd0 : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      fin_v_r <= 1'b1;
    end else if (fin_move) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      fin_sum_r <= sum;
      fin_fmt_r <= s1_fmt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fin_move) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) out_bits_r <= narrowed;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.sum_bits = out_bits_r;

  `FSSR_ASSERT_IMP(a_stall_only_last, s1_v_r && !adv, s1_last_r && fin_v_r && out_v_r)
  `FSSR_ASSERT_NEXT(a_acc_clear, adv && s1_last_r, acc_r == 32'd0)
  `FSSR_ASSERT_NEXT(a_fin_held, fin_v_r && !fin_move, fin_v_r && $stable(fin_sum_r))
endmodule

// ----- tb/tb_float_sum_scoreboard.sv -----
// Scoreboard for the float stream sum-reduce testbench: bit-exact predictor
// of the binary32 accumulation and the queue of expected sums.
// Depends on fssr_pkg for the format codes.
`timescale 1ns / 100ps

package tb_float_sum_sb_pkg;
  import fssr_pkg::*;

  class float_sum_scoreboard;
    logic [31:0] acc_total;
    logic [1:0]  cur_format;
    logic [31:0] sum_queue[$];
    int          err_count;
    int          sums_seen;

    function new();
      acc_total  = 32'h0;
      cur_format = FMT_FP32;
      err_count  = 0;
      sums_seen  = 0;
    endfunction

    function logic [31:0] half_to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] fr;
      int unsigned e32;
      sgn = {h[15], 31'h0};
      ex  = h[14:10];
      fr  = {1'b0, h[9:0]};
      if (ex == 5'd31) return sgn | 32'h7F80_0000 | (32'(fr[9:0]) << 13);
      if (ex == 5'd0) begin
        if (fr == 0) return sgn;
        e32 = 113;
        while (fr[10] == 1'b0) begin
          fr = fr << 1;
          e32--;
        end
        return sgn | (32'(e32) << 23) | (32'(fr[9:0]) << 13);
      end
      return sgn | ((32'(ex) + 32'd112) << 23) | (32'(fr[9:0]) << 13);
    endfunction

    function logic [31:0] single_to_half(logic [31:0] u);
      logic [31:0] sgn, ex, fr, m, q, rem, half, sh;
      int e16;
      sgn = (u >> 16) & 32'h8000;
      ex  = (u >> 23) & 32'hFF;
      fr  = u & 32'h7F_FFFF;
      if (ex == 255) return (fr != 0) ? (sgn | 32'h7E00 | (fr >> 13)) : (sgn | 32'h7C00);
      if (ex == 0) return sgn;
      m   = fr | 32'h80_0000;
      e16 = int'(ex) - 112;
      if (e16 >= 31) return sgn | 32'h7C00;
      if (e16 >= 1) begin
        rem = m & 32'h1FFF;
        q   = (32'(e16) << 10) + ((m >> 13) & 32'h3FF);
        if (rem > 32'h1000 || (rem == 32'h1000 && q[0])) q++;
        return sgn | q;
      end
      sh = 32'(14 - e16);
      if (sh >= 25) return sgn;
      q    = m >> sh;
      rem  = m & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return sgn | q;
    endfunction

    function logic [31:0] single_to_bf16(logic [31:0] u);
      if ((u & 32'h7F80_0000) == 32'h7F80_0000 && (u & 32'h7F_FFFF) != 0)
        return (u >> 16) | 32'h40;
      return (u + 32'h7FFF + ((u >> 16) & 1)) >> 16;
    endfunction

    function logic [31:0] add_single(logic [31:0] a, logic [31:0] b);
      logic [31:0] ea, eb, ma, mb, s, m, d, t, rb, ef;
      ea = (a >> 23) & 32'hFF; eb = (b >> 23) & 32'hFF;
      ma = a & 32'h7F_FFFF;    mb = b & 32'h7F_FFFF;
      if (ea == 255 && ma != 0) return a | 32'h40_0000;
      if (eb == 255 && mb != 0) return b | 32'h40_0000;
      if (ea == 255 || eb == 255) begin
        if (ea == 255 && eb == 255 && ((a ^ b) & 32'h8000_0000) != 0) return QNAN32;
        return (ea == 255) ? a : b;
      end
      if ((a & 32'h7FFF_FFFF) == 0 && (b & 32'h7FFF_FFFF) == 0)
        return a & b & 32'h8000_0000;
      if ((a & 32'h7FFF_FFFF) == 0) return b;
      if ((b & 32'h7FFF_FFFF) == 0) return a;
      if ((a & 32'h7FFF_FFFF) < (b & 32'h7FFF_FFFF)) begin
        t = a; a = b; b = t;
        t = ea; ea = eb; eb = t;
        t = ma; ma = mb; mb = t;
      end
      s = a & 32'h8000_0000;
      if (ea != 0) ma |= 32'h80_0000; else ea = 1;
      if (eb != 0) mb |= 32'h80_0000; else eb = 1;
      ma <<= 3;
      mb <<= 3;
      d = ea - eb;
      if (d >= 27) mb = 32'(mb != 0);
      else if (d > 0) begin
        t  = 32'((mb & ((32'd1 << d) - 1)) != 0);
        mb = (mb >> d) | t;
      end
      if (((a ^ b) & 32'h8000_0000) == 0) begin
        m = ma + mb;
        if (m[27]) begin
          m = (m >> 1) | (m & 1);
          ea++;
        end
      end else begin
        m = ma - mb;
        if (m == 0) return 32'h0;
        while (m < (32'd1 << 26) && ea > 1) begin
          m <<= 1;
          ea--;
        end
      end
      rb = m & 7;
      m >>= 3;
      if (rb > 4 || (rb == 4 && m[0])) m++;
      if (m == (32'd1 << 24)) begin
        m >>= 1;
        ea++;
      end
      if (ea >= 255) return s | 32'h7F80_0000;
      ef = m[23] ? ea : 32'h0;
      return s | (ef << 23) | (m & 32'h7F_FFFF);
    endfunction

    function void set_format(logic [1:0] fmt);
      cur_format = fmt;
    endfunction

    // One accepted element: widen, accumulate, and on last queue the sum.
    function void note_element(logic [31:0] bits, logic last);
      logic [31:0] wide, narrowed;
      if (cur_format == FMT_FP16)      wide = half_to_single(bits[15:0]);
      else if (cur_format == FMT_BF16) wide = {bits[15:0], 16'h0};
      else                             wide = bits;
      acc_total = add_single(acc_total, wide);
      if (last) begin
        if (cur_format == FMT_FP16)      narrowed = single_to_half(acc_total);
        else if (cur_format == FMT_BF16) narrowed = single_to_bf16(acc_total);
        else                             narrowed = acc_total;
        sum_queue.push_back(narrowed);
        acc_total = 32'h0;
      end
    endfunction

    function void check_sum(logic [31:0] got);
      logic [31:0] want;
      sums_seen++;
      if (sum_queue.size() == 0) begin
        $error("sum_bits: unexpected result 0x%08h", got);
        err_count++;
        return;
      end
      want = sum_queue.pop_front();
      if (got !== want) begin
        $error("sum_bits: expected 0x%08h actual 0x%08h", want, got);
        err_count++;
      end
    endfunction
  endclass
endpackage

// ----- tb/tb_top.sv -----
// Top of the float stream sum-reduce testbench: clock, reset, drivers for
// the element, result and format channels. Depends on fssr_pkg, fssr_if,
// float_stream_sum_reduce_unit and tb_float_sum_sb_pkg.
`timescale 1ns / 100ps

module tb_top;
  import fssr_pkg::*;
  import tb_float_sum_sb_pkg::*;

  logic clk;
  logic rst_n;

  fssr_in_if  in_ch();
  fssr_out_if out_ch();
  fssr_cfg_if cfg_ch();

  float_stream_sum_reduce_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  float_sum_scoreboard sb;

  // idle/stall controls
  bit quiet_mode;    // no random gaps on either side
  int sink_holdoff;  // cycles the result sink stays not ready
  int elems_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Limit: worst case is far below this.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Result sink: random stalls plus a long counted holdoff when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_sum(out_ch.sum_bits);
      if (sink_holdoff > 0) begin
        sink_holdoff--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 10);
      end
    end
  end

  // One element transaction; valid stays up back to back when no gap is drawn.
  task automatic send_element(logic [31:0] bits, logic last);
    in_ch.valid        <= 1'b1;
    in_ch.element_bits <= bits;
    in_ch.last_element <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_element(bits, last);
    elems_sent++;
    if (!quiet_mode && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait for every expected sum, then latency slack before idle-only actions.
  task automatic drain_sums();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.sum_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_format(logic [1:0] fmt);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.element_format <= fmt;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_format(fmt);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random element biased toward values that interact: ordinary magnitudes,
  // zeros, infinities, NaNs and subnormals.
  function automatic logic [31:0] pick_element(logic [1:0] fmt);
    logic [31:0] r;
    int k;
    r = $urandom();
    k = $urandom_range(99);
    if (fmt == FMT_FP16) begin
      if (k < 5)       r[14:0] = 15'h7C00;
      else if (k < 9)  r[14:10] = 5'h1F;
      else if (k < 15) r[14:10] = 5'h00;
      else if (k < 20) r[14:0] = 15'h0;
      else if (k < 70) r[14:10] = 5'($urandom_range(10, 20));
    end else begin
      // bfloat16 shares binary32's layout in the top half
      logic [31:0] v;
      v = (fmt == FMT_BF16) ? {r[15:0], 16'h0} : r;
      if (k < 5)       v[30:0] = 31'h7F80_0000;
      else if (k < 9)  v[30:23] = 8'hFF;
      else if (k < 15) v[30:23] = 8'h00;
      else if (k < 20) v[30:0] = 31'h0;
      else if (k < 24) v[30:23] = 8'($urandom_range(250, 254));
      else if (k < 70) v[30:23] = 8'($urandom_range(120, 134));
      r = (fmt == FMT_BF16) ? {r[31:16], v[31:16]} : v;
    end
    return r;
  endfunction

  initial begin
    logic [1:0] fmt;
    int len;
    sb = new();
    quiet_mode   = 1'b0;
    sink_holdoff = 0;
    elems_sent   = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.element_bits = '0;
    in_ch.last_element = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.element_format = FMT_FP32;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed binary32: zeros, infinities, NaN, overflow, cancellation, subnormals.
    send_element(32'h8000_0000, 1'b0); send_element(32'h8000_0000, 1'b1);  // -0 + -0
    send_element(32'h3F80_0000, 1'b0); send_element(32'hBF80_0000, 1'b1);  // cancels to +0
    send_element(32'h7F80_0000, 1'b0); send_element(32'hFF80_0000, 1'b1);  // opposite inf
    send_element(32'h7F80_0001, 1'b0); send_element(32'hFFA0_0000, 1'b1);  // NaN kept
    send_element(32'h7F7F_FFFF, 1'b0); send_element(32'h7F7F_FFFF, 1'b1);  // overflow
    send_element(32'h0000_0001, 1'b0); send_element(32'h807F_FFFF, 1'b1);  // subnormals
    send_element(32'hFFFF_FFFF, 1'b1);
    drain_sums();
    // Directed binary16.
    write_format(FMT_FP16);
    send_element(32'hFFFF_7BFF, 1'b0); send_element(32'h0000_7BFF, 1'b1);  // overflow
    send_element(32'h0000_0001, 1'b0); send_element(32'h0000_8000, 1'b1);  // subnormal
    send_element(32'h0000_7D01, 1'b1);                                      // NaN narrow
    send_element(32'h0000_FC00, 1'b1);
    drain_sums();
    // Directed bfloat16.
    write_format(FMT_BF16);
    send_element(32'h0000_7F7F, 1'b0); send_element(32'h0000_7F7F, 1'b1);
    send_element(32'h0000_FF81, 1'b1);
    send_element(32'h0000_3F80, 1'b0); send_element(32'h0000_3B80, 1'b1);
    drain_sums();
    // Unused code 3 decodes as binary32.
    write_format(2'd3);
    send_element(32'h4000_0000, 1'b0); send_element(32'h3F80_0001, 1'b1);
    drain_sums();

    // Random phases across formats; short tensors, occasional long ones.
    while (elems_sent < 820) begin
      fmt = 2'($urandom_range(0, 3));
      write_format(fmt);
      quiet_mode = ($urandom_range(9) == 0);
      repeat ($urandom_range(5, 15)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_element(pick_element(fmt), i == len - 1);
      end
      // Mid-stream format change: leave a partial tensor, switch, finish.
      if ($urandom_range(3) == 0) begin
        send_element(pick_element(fmt), 1'b0);
        drain_sums();
        fmt = 2'($urandom_range(0, 2));
        write_format(fmt);
        send_element(pick_element(fmt), 1'b1);
      end
      // Backpressure: sink holds off while elements keep coming.
      if ($urandom_range(3) == 0) begin
        sink_holdoff = 60;
        repeat (20) send_element(pick_element(fmt), 1'($urandom_range(1)));
      end
      drain_sums();  // sender pauses until every sum is back
    end
    quiet_mode = 1'b0;
    send_element(32'h0, 1'b1);
    drain_sums();
    repeat (10) @(posedge clk);

    $display("tb_top: %0d elements sent, %0d sums checked over all formats",
             elems_sent, sb.sums_seen);
    $display("tb_top: covered zeros, infinities, NaNs, subnormals, overflow, backpressure");
    if (sb.err_count == 0 && sb.sum_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/fssr_pkg.sv
rtl/fssr_if.sv
rtl/fssr_widen.sv
rtl/fssr_add.sv
rtl/fssr_narrow.sv
rtl/float_stream_sum_reduce_unit.sv
tb/tb_float_sum_scoreboard.sv
tb/tb_top.sv
